@@ design/sdhs_pkg.sv @@
package sdhs_pkg;

   localparam int MAX_REQUESTS = 32;
   localparam int CYL_BITS     = 16;
   localparam int TOTAL_BITS   = CYL_BITS + 1;
   localparam int COUNT_BITS   = $clog2(MAX_REQUESTS + 1);
   localparam int IDX_BITS     = $clog2(MAX_REQUESTS);
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = CYL_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_HEAD   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SWEEP_RIGHT  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_CYLINDER = 2'd2;

   localparam logic [CYL_BITS-1:0] START_HEAD_RESET   = CYL_BITS'(0);
   localparam logic                SWEEP_RIGHT_RESET  = 1'b1;
   localparam logic [CYL_BITS-1:0] MAX_CYLINDER_RESET = CYL_BITS'(199);

   typedef struct packed {
      logic [CYL_BITS-1:0] cylinder;
      logic                last;
   } req_type;

   typedef struct packed {
      logic [CYL_BITS-1:0]   from_cylinder;
      logic [CYL_BITS-1:0]   to_cylinder;
      logic [CYL_BITS-1:0]   distance;
      logic [TOTAL_BITS-1:0] total_movement;
      logic                  is_end_move;
      logic                  overflowed;
      logic [COUNT_BITS-1:0] request_count;
      logic                  final_move;
   } rsp_type;

   typedef struct packed {
      logic [CYL_BITS-1:0] start_head;
      logic                sweep_right;
      logic [CYL_BITS-1:0] max_cylinder;
   } cfg_type;

   // front queue status as seen by the back end
   typedef struct packed {
      logic    empty;
      req_type head;
   } fq_status_type;

   typedef enum logic [2:0] {
      S_LOAD,
      S_FETCH,
      S_EMIT,
      S_END
   } sweep_state_type;

endpackage

@@ design/sdhs_front.sv @@
module sdhs_front (
   input  logic              clock,
   input  logic              reset,
   input  sdhs_pkg::cfg_type cfg,
   input  logic              req_push,
   output logic              req_full,
   input  sdhs_pkg::req_type req_data,
   input  logic              fq_pop,
   output sdhs_pkg::fq_status_type fq_status
);

   sdhs_pkg::req_type                    mem_ff [sdhs_pkg::QUEUE_DEPTH];
   logic [sdhs_pkg::QPTR_BITS-1:0]       wp_ff, wp_in;
   logic [sdhs_pkg::QPTR_BITS-1:0]       rp_ff, rp_in;
   logic [sdhs_pkg::QCNT_BITS-1:0]       cnt_ff, cnt_in;
   sdhs_pkg::req_type                    clamped;
   logic                                 do_push;
   logic                                 do_pop;

   always_comb begin
      clamped      = req_data;
      if (req_data.cylinder > cfg.max_cylinder) begin
         clamped.cylinder = cfg.max_cylinder;
      end
   end

   assign req_full        = (cnt_ff == sdhs_pkg::QCNT_BITS'(sdhs_pkg::QUEUE_DEPTH));
   assign do_push         = req_push && !req_full;
   assign do_pop          = fq_pop && (cnt_ff != '0);
   assign fq_status.empty = (cnt_ff == '0);
   assign fq_status.head  = mem_ff[rp_ff];

   always_comb begin
      wp_in  = do_push ? sdhs_pkg::QPTR_BITS'(wp_ff + 1'b1) : wp_ff;
      rp_in  = do_pop  ? sdhs_pkg::QPTR_BITS'(rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wp_ff] <= clamped;
      end
   end

   a_fq_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= sdhs_pkg::QCNT_BITS'(sdhs_pkg::QUEUE_DEPTH))
      else $error("front queue count beyond depth");

endmodule

@@ design/sdhs_back.sv @@
module sdhs_back (
   input  logic                    clock,
   input  logic                    reset,
   input  sdhs_pkg::cfg_type       cfg,
   input  sdhs_pkg::fq_status_type fq_status,
   output logic                    fq_pop,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output sdhs_pkg::rsp_type       rsp_data
);

   localparam int N  = sdhs_pkg::MAX_REQUESTS;
   localparam int CB = sdhs_pkg::COUNT_BITS;
   localparam int IB = sdhs_pkg::IDX_BITS;
   localparam int WB = sdhs_pkg::CYL_BITS;
   localparam int TB = sdhs_pkg::TOTAL_BITS;

   sdhs_pkg::sweep_state_type state_ff, state_in;

   logic [WB-1:0] store_ff [N];
   logic [CB-1:0] count_ff;
   logic          dropped_ff;
   logic [WB-1:0] head_ff;
   logic [TB-1:0] total_ff;
   logic [WB-1:0] start_ff;
   logic          phase_a_ff;
   logic [IB-1:0] idx_ff;
   logic [CB-1:0] rem_ff;
   logic [WB-1:0] cand_ff;
   logic          hit_ff;

   // result queue
   sdhs_pkg::rsp_type                res_mem_ff [sdhs_pkg::QUEUE_DEPTH];
   logic [sdhs_pkg::QPTR_BITS-1:0]   res_wp_ff;
   logic [sdhs_pkg::QPTR_BITS-1:0]   res_rp_ff;
   logic [sdhs_pkg::QCNT_BITS-1:0]   res_cnt_ff;
   logic                             res_full;
   logic                             res_push;
   logic                             res_pop;
   sdhs_pkg::rsp_type                res_item;

   logic          store_full;
   logic [CB-1:0] cnt_m1;
   logic [CB-1:0] last_pos;
   logic          up;
   logic          last_idx;
   logic          rem_one;
   logic          rem_zero;
   logic [WB-1:0] new_cyl;
   logic [N-1:0]  gt;
   logic [N-1:0]  ins_we;
   logic [WB-1:0] ins_val [N];
   logic [WB-1:0] rd_val;
   logic          match_a;
   logic [WB-1:0] start_clamped;
   logic [WB-1:0] end_cyl;
   logic [WB-1:0] to_cyl;
   logic [WB-1:0] move_dist;
   logic [TB-1:0] total_next;

   // decoded controls
   logic do_load;
   logic do_fetch;
   logic do_step;
   logic do_end;
   logic finish;

   assign store_full = (count_ff == CB'(N));
   assign cnt_m1     = count_ff - CB'(1);
   assign last_pos   = store_full ? cnt_m1 : count_ff;
   assign up         = phase_a_ff ? cfg.sweep_right : !cfg.sweep_right;
   assign last_idx   = up ? (idx_ff == cnt_m1[IB-1:0]) : (idx_ff == '0);
   assign rem_one    = (rem_ff == CB'(1));
   assign rem_zero   = (rem_ff == '0);
   assign new_cyl    = fq_status.head.cylinder;
   assign end_cyl    = cfg.sweep_right ? cfg.max_cylinder : '0;
   assign start_clamped = (cfg.start_head > cfg.max_cylinder) ? cfg.max_cylinder
                                                              : cfg.start_head;

   // sorted insertion: every entry above the new value moves up by one
   always_comb begin
      for (int i = 0; i < N; i++) begin
         gt[i]     = (CB'(i) < count_ff) && (store_ff[i] > new_cyl);
         ins_we[i] = gt[i] || (CB'(i) == count_ff);
      end
      ins_val[0] = new_cyl;
      for (int i = 1; i < N; i++) begin
         ins_val[i] = gt[i-1] ? store_ff[i-1] : new_cyl;
      end
   end

   assign rd_val  = store_ff[idx_ff];
   assign match_a = cfg.sweep_right ? (rd_val >= start_ff) : (rd_val <= start_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sdhs_pkg::S_LOAD: begin
            if (!fq_status.empty && fq_status.head.last) begin
               state_in = sdhs_pkg::S_FETCH;
            end
         end
         sdhs_pkg::S_FETCH: begin
            state_in = sdhs_pkg::S_EMIT;
         end
         sdhs_pkg::S_EMIT: begin
            if (!(hit_ff && res_full)) begin
               if (phase_a_ff) begin
                  state_in = last_idx ? sdhs_pkg::S_END : sdhs_pkg::S_FETCH;
               end else if ((hit_ff && rem_one) || last_idx) begin
                  state_in = sdhs_pkg::S_LOAD;
               end else begin
                  state_in = sdhs_pkg::S_FETCH;
               end
            end
         end
         sdhs_pkg::S_END: begin
            if (!res_full) begin
               state_in = rem_zero ? sdhs_pkg::S_LOAD : sdhs_pkg::S_FETCH;
            end
         end
         default: state_in = sdhs_pkg::S_LOAD;
      endcase
   end

   // control outputs
   always_comb begin
      do_load  = 1'b0;
      do_fetch = 1'b0;
      do_step  = 1'b0;
      do_end   = 1'b0;
      finish   = 1'b0;
      res_push = 1'b0;
      unique case (state_ff)
         sdhs_pkg::S_LOAD: begin
            do_load = !fq_status.empty;
         end
         sdhs_pkg::S_FETCH: begin
            do_fetch = 1'b1;
         end
         sdhs_pkg::S_EMIT: begin
            do_step  = !(hit_ff && res_full);
            res_push = hit_ff && !res_full;
            finish   = do_step && !phase_a_ff && ((hit_ff && rem_one) || last_idx);
         end
         sdhs_pkg::S_END: begin
            do_end   = !res_full;
            res_push = !res_full;
            finish   = !res_full && rem_zero;
         end
         default: begin
            do_load = 1'b0;
         end
      endcase
   end

   assign fq_pop = do_load;

   // move arithmetic
   always_comb begin
      to_cyl     = do_end ? end_cyl : cand_ff;
      move_dist  = (to_cyl >= head_ff) ? (to_cyl - head_ff) : (head_ff - to_cyl);
      total_next = TB'(total_ff + TB'(move_dist));

      res_item.from_cylinder  = head_ff;
      res_item.to_cylinder    = to_cyl;
      res_item.distance       = move_dist;
      res_item.total_movement = total_next;
      res_item.is_end_move    = do_end;
      res_item.overflowed     = dropped_ff;
      res_item.request_count  = count_ff;
      res_item.final_move     = do_end ? rem_zero : (!phase_a_ff && rem_one);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sdhs_pkg::S_LOAD;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         head_ff    <= '0;
         total_ff   <= '0;
         phase_a_ff <= 1'b1;
         idx_ff     <= '0;
         rem_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (do_load) begin
            if (store_full) begin
               dropped_ff <= 1'b1;
            end else begin
               count_ff <= count_ff + CB'(1);
            end
            // running total restarts when the batch closes
            if (fq_status.head.last) begin
               head_ff    <= start_clamped;
               total_ff   <= '0;
               phase_a_ff <= 1'b1;
               rem_ff     <= '0;
               idx_ff     <= cfg.sweep_right ? '0 : last_pos[IB-1:0];
            end
         end
         if (do_step) begin
            if (res_push) begin
               head_ff  <= to_cyl;
               total_ff <= total_next;
            end
            if (phase_a_ff && !hit_ff) begin
               rem_ff <= rem_ff + CB'(1);
            end else if (!phase_a_ff && hit_ff) begin
               rem_ff <= rem_ff - CB'(1);
            end
            if (!last_idx) begin
               idx_ff <= up ? IB'(idx_ff + 1'b1) : IB'(idx_ff - 1'b1);
            end
         end
         if (do_end) begin
            head_ff    <= to_cyl;
            total_ff   <= total_next;
            phase_a_ff <= 1'b0;
            idx_ff     <= cfg.sweep_right ? cnt_m1[IB-1:0] : '0;
         end
         if (finish) begin
            count_ff   <= '0;
            dropped_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_load && fq_status.head.last) begin
         start_ff <= start_clamped;
      end
      if (do_fetch) begin
         cand_ff <= rd_val;
         hit_ff  <= phase_a_ff ? match_a : !match_a;
      end
      if (do_load && !store_full) begin
         for (int i = 0; i < N; i++) begin
            if (ins_we[i]) begin
               store_ff[i] <= ins_val[i];
            end
         end
      end
   end

   // result queue
   assign res_full  = (res_cnt_ff == sdhs_pkg::QCNT_BITS'(sdhs_pkg::QUEUE_DEPTH));
   assign rsp_empty = (res_cnt_ff == '0);
   assign res_pop   = rsp_pop && !rsp_empty;
   assign rsp_data  = res_mem_ff[res_rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         res_wp_ff  <= '0;
         res_rp_ff  <= '0;
         res_cnt_ff <= '0;
      end else begin
         if (res_push) begin
            res_wp_ff <= sdhs_pkg::QPTR_BITS'(res_wp_ff + 1'b1);
         end
         if (res_pop) begin
            res_rp_ff <= sdhs_pkg::QPTR_BITS'(res_rp_ff + 1'b1);
         end
         if (res_push && !res_pop) begin
            res_cnt_ff <= res_cnt_ff + 1'b1;
         end else if (res_pop && !res_push) begin
            res_cnt_ff <= res_cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         res_mem_ff[res_wp_ff] <= res_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(N))
      else $error("stored request count beyond store size");

   a_drop_only_full: assert property (@(posedge clock) disable iff (reset)
      dropped_ff |-> (count_ff == CB'(N)))
      else $error("drop flag set while store has room");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sdhs_pkg::S_FETCH || state_ff == sdhs_pkg::S_EMIT)
         |-> (CB'(idx_ff) < count_ff))
      else $error("sweep index outside stored requests");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full)
      else $error("result pushed into full queue");

endmodule

@@ design/scan_disk_head_scheduler_core.sv @@
// Channel   Ports                                 Carries
// request   req_push, req_full, req_data          one cylinder request, last closes batch
// result    rsp_pop, rsp_empty, rsp_data          one head move
// config    csr_write_en, csr_index, csr_wdata    start_head, sweep_right, max_cylinder
//
// A request is written into the 2-entry front queue; the back end pops it from there and
// sorts it into the store, so a batch loads at one request per cycle while the back end is in its load state.
// The sweep goes through a store read (S_FETCH) and a move step (S_EMIT) for every stored
// request in the first pass, then the end move (S_END), and the same read and move steps per
// entry of the return pass until the last move is queued.
// Reset is synchronous; a full result queue stalls the sweep, requests keep queueing until the front queue is full.
module scan_disk_head_scheduler_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  sdhs_pkg::req_type                      req_data,
   input  logic                                   rsp_pop,
   output logic                                   rsp_empty,
   output sdhs_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_write_en,
   input  logic [sdhs_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [sdhs_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   sdhs_pkg::cfg_type       cfg_ff;
   sdhs_pkg::fq_status_type fq_status;
   logic                    fq_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_head   <= sdhs_pkg::START_HEAD_RESET;
         cfg_ff.sweep_right  <= sdhs_pkg::SWEEP_RIGHT_RESET;
         cfg_ff.max_cylinder <= sdhs_pkg::MAX_CYLINDER_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            sdhs_pkg::CSR_START_HEAD:   cfg_ff.start_head   <= csr_wdata;
            sdhs_pkg::CSR_SWEEP_RIGHT:  cfg_ff.sweep_right  <= csr_wdata[0];
            sdhs_pkg::CSR_MAX_CYLINDER: cfg_ff.max_cylinder <= csr_wdata;
            default: ;
         endcase
      end
   end

   sdhs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .fq_pop    (fq_pop),
      .fq_status (fq_status)
   );

   sdhs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .fq_status (fq_status),
      .fq_pop    (fq_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

@@ tb/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 150;
   localparam int CYCLE_LIMIT   = 2000000;

   logic              clock        = 1'b0;
   logic              reset        = 1'b1;
   logic              req_push     = 1'b0;
   logic              req_full;
   sdhs_pkg::req_type req_data     = '0;
   logic              rsp_pop      = 1'b0;
   logic              rsp_empty;
   sdhs_pkg::rsp_type rsp_data;
   logic              csr_write_en = 1'b0;
   logic [sdhs_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [sdhs_pkg::CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // scheduler shadow: configuration, sorted store and batch flags
   sdhs_pkg::cfg_type sched_cfg = '{start_head: sdhs_pkg::START_HEAD_RESET,
                                    sweep_right: sdhs_pkg::SWEEP_RIGHT_RESET,
                                    max_cylinder: sdhs_pkg::MAX_CYLINDER_RESET};
   logic [sdhs_pkg::CYL_BITS-1:0] sorted_cyl [sdhs_pkg::MAX_REQUESTS];
   int                  kept_count = 0;
   logic                lost_any   = 1'b0;

   sdhs_pkg::req_type pending_requests [$];
   sdhs_pkg::rsp_type expected_moves [$];

   bit      send_idle = 1'b0;
   bit      take_idle = 1'b0;
   int      send_gap  = 0;
   int      take_gap  = 0;
   int      mismatch_count = 0;
   int      move_count = 0;
   int      cycle_count = 0;
   sdhs_pkg::rsp_type want;
   string   diffs;

   scan_disk_head_scheduler_core i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_data     (req_data),
      .rsp_pop      (rsp_pop),
      .rsp_empty    (rsp_empty),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("%0t ERROR %s", $time, msg);
   endtask

   // sorted insert; a closing request expands the whole elevator sweep into moves
   task automatic schedule_request(input sdhs_pkg::req_type req);
      logic [sdhs_pkg::CYL_BITS-1:0]   cyl;
      logic [sdhs_pkg::CYL_BITS-1:0]   start;
      logic [sdhs_pkg::CYL_BITS-1:0]   head;
      logic [sdhs_pkg::CYL_BITS-1:0]   step_dist;
      logic [sdhs_pkg::TOTAL_BITS-1:0] total;
      logic [sdhs_pkg::CYL_BITS:0]     stops [$];
      sdhs_pkg::rsp_type               move;
      int                              pos;
      cyl = (req.cylinder > sched_cfg.max_cylinder) ? sched_cfg.max_cylinder : req.cylinder;
      if (kept_count >= sdhs_pkg::MAX_REQUESTS) begin
         lost_any = 1'b1;
      end else begin
         pos = kept_count;
         while (pos > 0 && sorted_cyl[pos-1] > cyl) begin
            sorted_cyl[pos] = sorted_cyl[pos-1];
            pos--;
         end
         sorted_cyl[pos] = cyl;
         kept_count++;
      end
      if (!req.last) return;

      start = (sched_cfg.start_head > sched_cfg.max_cylinder) ?
              sched_cfg.max_cylinder : sched_cfg.start_head;
      // stop entries carry the end-move flag in the top bit
      if (sched_cfg.sweep_right) begin
         for (int i = 0; i < kept_count; i++)
            if (sorted_cyl[i] >= start) stops.push_back({1'b0, sorted_cyl[i]});
         stops.push_back({1'b1, sched_cfg.max_cylinder});
         for (int i = kept_count - 1; i >= 0; i--)
            if (sorted_cyl[i] < start) stops.push_back({1'b0, sorted_cyl[i]});
      end else begin
         for (int i = kept_count - 1; i >= 0; i--)
            if (sorted_cyl[i] <= start) stops.push_back({1'b0, sorted_cyl[i]});
         stops.push_back({1'b1, {sdhs_pkg::CYL_BITS{1'b0}}});
         for (int i = 0; i < kept_count; i++)
            if (sorted_cyl[i] > start) stops.push_back({1'b0, sorted_cyl[i]});
      end

      head  = start;
      total = '0;
      foreach (stops[k]) begin
         step_dist = (stops[k][sdhs_pkg::CYL_BITS-1:0] >= head) ?
                     stops[k][sdhs_pkg::CYL_BITS-1:0] - head :
                     head - stops[k][sdhs_pkg::CYL_BITS-1:0];
         total = total + sdhs_pkg::TOTAL_BITS'(step_dist);
         move.from_cylinder  = head;
         move.to_cylinder    = stops[k][sdhs_pkg::CYL_BITS-1:0];
         move.distance       = step_dist;
         move.total_movement = total;
         move.is_end_move    = stops[k][sdhs_pkg::CYL_BITS];
         move.overflowed     = lost_any;
         move.request_count  = sdhs_pkg::COUNT_BITS'(kept_count);
         move.final_move     = (k == stops.size() - 1);
         expected_moves.push_back(move);
         head = stops[k][sdhs_pkg::CYL_BITS-1:0];
      end
      kept_count = 0;
      lost_any   = 1'b0;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_push && !req_full) schedule_request(req_data);
         if (!req_push || !req_full) begin
            if (send_gap > 0) begin
               send_gap--;
               req_push <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               req_data <= pending_requests.pop_front();
               req_push <= 1'b1;
               send_gap = send_idle ? $urandom_range(0, 9) : 0;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // move monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         take_gap = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            move_count++;
            if (expected_moves.size() == 0) begin
               report_mismatch($sformatf("move %0d unexpected: %0d -> %0d", move_count,
                                         rsp_data.from_cylinder, rsp_data.to_cylinder));
            end else begin
               want  = expected_moves.pop_front();
               diffs = "";
               if (rsp_data.from_cylinder !== want.from_cylinder)
                  diffs = {diffs, $sformatf(" from %0d/%0d", rsp_data.from_cylinder,
                                            want.from_cylinder)};
               if (rsp_data.to_cylinder !== want.to_cylinder)
                  diffs = {diffs, $sformatf(" to %0d/%0d", rsp_data.to_cylinder,
                                            want.to_cylinder)};
               if (rsp_data.distance !== want.distance)
                  diffs = {diffs, $sformatf(" distance %0d/%0d", rsp_data.distance,
                                            want.distance)};
               if (rsp_data.total_movement !== want.total_movement)
                  diffs = {diffs, $sformatf(" total %0d/%0d", rsp_data.total_movement,
                                            want.total_movement)};
               if (rsp_data.is_end_move !== want.is_end_move)
                  diffs = {diffs, $sformatf(" end %b/%b", rsp_data.is_end_move,
                                            want.is_end_move)};
               if (rsp_data.overflowed !== want.overflowed)
                  diffs = {diffs, $sformatf(" overflow %b/%b", rsp_data.overflowed,
                                            want.overflowed)};
               if (rsp_data.request_count !== want.request_count)
                  diffs = {diffs, $sformatf(" count %0d/%0d", rsp_data.request_count,
                                            want.request_count)};
               if (rsp_data.final_move !== want.final_move)
                  diffs = {diffs, $sformatf(" final %b/%b", rsp_data.final_move,
                                            want.final_move)};
               if (diffs != "")
                  report_mismatch($sformatf("move %0d (got/expected):%s", move_count, diffs));
            end
            take_gap = take_idle ? $urandom_range(0, 9) : 0;
         end
         if (take_gap > 0) begin
            take_gap--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic write_csr(input logic [sdhs_pkg::CSR_INDEX_BITS-1:0] index,
                            input logic [sdhs_pkg::CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (index)
         sdhs_pkg::CSR_START_HEAD:   sched_cfg.start_head   = value;
         sdhs_pkg::CSR_SWEEP_RIGHT:  sched_cfg.sweep_right  = value[0];
         sdhs_pkg::CSR_MAX_CYLINDER: sched_cfg.max_cylinder = value;
         default: ;
      endcase
   endtask

   task automatic program_sweep(input logic [sdhs_pkg::CYL_BITS-1:0] start,
                                input logic right,
                                input logic [sdhs_pkg::CYL_BITS-1:0] max_cyl);
      write_csr(sdhs_pkg::CSR_START_HEAD, start);
      write_csr(sdhs_pkg::CSR_SWEEP_RIGHT, sdhs_pkg::CSR_DATA_BITS'(right));
      write_csr(sdhs_pkg::CSR_MAX_CYLINDER, max_cyl);
   endtask

   task automatic add_request(input logic [sdhs_pkg::CYL_BITS-1:0] cyl, input logic last);
      sdhs_pkg::req_type req;
      req.cylinder = cyl;
      req.last     = last;
      pending_requests.push_back(req);
   endtask

   // random batch with a bias toward ties, extremes and the start cylinder
   task automatic queue_batch(input int size);
      logic [sdhs_pkg::CYL_BITS-1:0] cyl;
      cyl = '0;
      for (int k = 0; k < size; k++) begin
         case ($urandom_range(0, 9)) inside
            [0:4]:   cyl = sdhs_pkg::CYL_BITS'($urandom_range(0, sched_cfg.max_cylinder));
            5:       cyl = sdhs_pkg::CYL_BITS'($urandom);
            6:       cyl = sched_cfg.start_head;
            7:       cyl = '0;
            8:       cyl = $urandom_range(0, 1) ? sched_cfg.max_cylinder : '1;
            default: ;  // repeat previous cylinder
         endcase
         add_request(cyl, k == size - 1);
      end
   endtask

   // sampled away from the active edge so pending driver updates have settled
   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_push || expected_moves.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [sdhs_pkg::CYL_BITS-1:0] max_cyl;
      logic [sdhs_pkg::CYL_BITS-1:0] start;
      int                            queued;
      int                            size;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset configuration: clamped request, request at start head, zero-length end move
      add_request(16'd0, 1'b0);
      add_request(16'd199, 1'b0);
      add_request(16'hFFFF, 1'b0);
      add_request(16'd100, 1'b1);
      add_request(16'd50, 1'b1);
      wait_drained();

      // leftward sweep with return pass
      send_idle = 1'b1;
      take_idle = 1'b1;
      program_sweep(16'd100, 1'b0, 16'd199);
      add_request(16'd100, 1'b0);
      add_request(16'd20, 1'b0);
      add_request(16'd150, 1'b0);
      add_request(16'd180, 1'b0);
      add_request(16'd0, 1'b1);
      wait_drained();

      // start head above disk end
      program_sweep(16'hFFFF, 1'b1, 16'd1000);
      add_request(16'd1000, 1'b0);
      add_request(16'd999, 1'b0);
      add_request(16'hFFFF, 1'b0);
      add_request(16'd5, 1'b1);
      wait_drained();

      // smallest disk
      program_sweep(16'd0, 1'b0, 16'd1);
      add_request(16'd1, 1'b0);
      add_request(16'd0, 1'b1);
      wait_drained();

      // widest disk
      send_idle = 1'b0;
      program_sweep(16'h8000, 1'b1, 16'hFFFF);
      add_request(16'hFFFF, 1'b0);
      add_request(16'd0, 1'b0);
      add_request(16'hAAAA, 1'b0);
      add_request(16'h5555, 1'b1);
      wait_drained();

      for (int phase = 0; phase < 10; phase++) begin
         case ($urandom_range(0, 4))
            0:       max_cyl = 16'd1;
            1:       max_cyl = 16'd199;
            2:       max_cyl = 16'hFFFF;
            default: max_cyl = sdhs_pkg::CYL_BITS'($urandom_range(2, 65535));
         endcase
         case ($urandom_range(0, 3))
            0:       start = '0;
            1:       start = '1;
            default: start = sdhs_pkg::CYL_BITS'($urandom_range(0, max_cyl));
         endcase
         program_sweep(start, 1'($urandom_range(0, 1)), max_cyl);
         send_idle = ($urandom_range(0, 3) != 0);
         take_idle = ($urandom_range(0, 3) != 0);
         queued = 0;
         // the first random phase always overruns the store
         if (phase == 0) begin
            size = $urandom_range(sdhs_pkg::MAX_REQUESTS + 1, sdhs_pkg::MAX_REQUESTS + 8);
            queue_batch(size);
            queued += size;
         end
         while (queued < 25) begin
            size = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            queue_batch(size);
            queued += size;
         end
         wait_drained();
      end

      if (mismatch_count == 0 && expected_moves.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ scan_disk_head_scheduler_core.f @@
design/sdhs_pkg.sv
design/sdhs_front.sv
design/sdhs_back.sv
design/scan_disk_head_scheduler_core.sv
tb/tb_top.sv
